// File: hdl/enfa_pkg.sv
// Shared types and constants of the epsilon-NFA acceptor.
// Used by epsilon_nfa_acceptor and tb_top; depends on nothing.
package enfa_pkg;

   // Automaton size
   localparam int NUM_STATES  = 16;
   localparam int NUM_SYMBOLS = 16;
   localparam int STATE_W     = 4;
   localparam int SYM_W       = 4;
   localparam int SYM_ROWS    = NUM_STATES * NUM_SYMBOLS;
   localparam int SYM_ADDR_W  = STATE_W + SYM_W;
   localparam int SCAN_W      = STATE_W + 1;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_MASK = 1'd1;

   typedef logic [NUM_STATES-1:0] state_set_type;

   typedef enum logic [1:0] {
      MODE_LOAD_SYM   = 2'd0,
      MODE_LOAD_EMPTY = 2'd1,
      MODE_SYMBOL     = 2'd2,
      MODE_END        = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type          mode;
      logic [STATE_W-1:0] from_state;
      logic [SYM_W-1:0]   symbol;
      logic [15:0]        target_mask;
   } req_type;

   typedef struct packed {
      logic accepted;
      logic no_live_states;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_MOVE,
      ST_REPORT
   } seq_state_type;

endpackage

// File: hdl/enfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the transition tables of the acceptor; no dependencies.
module enfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/epsilon_nfa_acceptor.sv
// Top level of the epsilon-NFA acceptor: sequencer, table memories, CSRs.
// Depends on enfa_pkg and enfa_ram.
//
// Usage: items arrive on req_ (valid/ready). Mode 0 and 1 items load one
// symbol-transition row or one empty-move row and give no result. Mode 2
// items feed one word symbol, mode 3 ends the word and produces one rsp_
// item (accepted, no_live_states); the next word then starts again at
// start_state. csr_ writes set start_state and accept_mask and take effect
// at once; write them only while the block is idle.
// Each empty-move closure pass and each symbol move scans all 16 table
// rows through the single read port of its memory, one row per cycle. A
// word item runs P closure passes, where P (1 to 16) is one more than the
// number of passes that grow the set; a symbol item then runs one move.
// No new item is accepted until the sequencer is back in idle.
// A finished result sits in an output register; the next item is accepted
// while it waits, and only a second result waits for rsp_ready.
// Reset (synchronous) clears both tables through per-row valid bits, the
// active set, the configuration registers and the result valid flag; no clearing pass.
module epsilon_nfa_acceptor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  enfa_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output enfa_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_we,
   input  logic [enfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [enfa_pkg::CSR_W-1:0]          csr_wdata
);

   // Configuration registers
   logic [enfa_pkg::STATE_W-1:0] start_state_ff;
   enfa_pkg::state_set_type      accept_mask_ff;

   // Sequencer state
   enfa_pkg::seq_state_type      state_ff, state_in;
   logic [enfa_pkg::SCAN_W-1:0]  cnt_ff, cnt_in;
   logic                         rd_live_ff, rd_live_in;
   logic [enfa_pkg::STATE_W-1:0] rd_idx_ff, rd_idx_in;
   logic                         rd_vld_ff, rd_vld_in;
   enfa_pkg::state_set_type      set_ff, set_in;
   enfa_pkg::state_set_type      grown_ff, grown_in;
   logic                         word_fresh_ff, word_fresh_in;
   logic                         cur_end_ff, cur_end_in;
   logic [enfa_pkg::SYM_W-1:0]   cur_sym_ff, cur_sym_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   enfa_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   // Table valid bits (an invalid row reads as all zeros)
   logic [enfa_pkg::SYM_ROWS-1:0]   sym_vld_ff;
   logic [enfa_pkg::NUM_STATES-1:0] emp_vld_ff;

   // Memory ports
   logic                            req_fire;
   logic                            sym_we, emp_we;
   logic [enfa_pkg::SYM_ADDR_W-1:0] sym_wr_addr, sym_rd_addr;
   logic                            sym_re, emp_re;
   enfa_pkg::state_set_type         sym_rd_data, emp_rd_data;
   enfa_pkg::state_set_type         row, acc, start_set;
   logic                            issue, scan_done;

   assign req_fire    = req_valid && req_ready;
   assign sym_we      = req_fire && (req_payload.mode == enfa_pkg::MODE_LOAD_SYM);
   assign emp_we      = req_fire && (req_payload.mode == enfa_pkg::MODE_LOAD_EMPTY);
   assign sym_wr_addr = {req_payload.from_state, req_payload.symbol};
   assign sym_rd_addr = {cnt_ff[enfa_pkg::STATE_W-1:0], cur_sym_ff};
   assign issue       = ((state_ff == enfa_pkg::ST_CLOSE) || (state_ff == enfa_pkg::ST_MOVE))
                        && !cnt_ff[enfa_pkg::SCAN_W-1];
   assign sym_re      = issue && (state_ff == enfa_pkg::ST_MOVE);
   assign emp_re      = issue && (state_ff == enfa_pkg::ST_CLOSE);
   assign scan_done   = cnt_ff[enfa_pkg::SCAN_W-1];
   assign start_set   = enfa_pkg::state_set_type'(1) << start_state_ff;

   // Symbol-transition table: row address is {from_state, symbol}
   enfa_ram #(
      .WIDTH(enfa_pkg::NUM_STATES),
      .DEPTH(enfa_pkg::SYM_ROWS)
   ) u_sym_ram (
      .clock  (clock),
      .wr_en  (sym_we),
      .wr_addr(sym_wr_addr),
      .wr_data(req_payload.target_mask),
      .rd_en  (sym_re),
      .rd_addr(sym_rd_addr),
      .rd_data(sym_rd_data)
   );

   // Empty-move table: one row per source state
   enfa_ram #(
      .WIDTH(enfa_pkg::NUM_STATES),
      .DEPTH(enfa_pkg::NUM_STATES)
   ) u_emp_ram (
      .clock  (clock),
      .wr_en  (emp_we),
      .wr_addr(req_payload.from_state),
      .wr_data(req_payload.target_mask),
      .rd_en  (emp_re),
      .rd_addr(cnt_ff[enfa_pkg::STATE_W-1:0]),
      .rd_data(emp_rd_data)
   );

   // Returned row, qualified by its valid bit and the active set
   always_comb begin
      row = (state_ff == enfa_pkg::ST_CLOSE) ? emp_rd_data : sym_rd_data;
      if (rd_live_ff && rd_vld_ff && set_ff[rd_idx_ff]) begin
         acc = grown_ff | row;
      end else begin
         acc = grown_ff;
      end
   end

   // Next state and datapath control
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_live_in    = issue;
      rd_idx_in     = cnt_ff[enfa_pkg::STATE_W-1:0];
      rd_vld_in     = (state_ff == enfa_pkg::ST_CLOSE) ?
                      emp_vld_ff[cnt_ff[enfa_pkg::STATE_W-1:0]] : sym_vld_ff[sym_rd_addr];
      set_in        = set_ff;
      grown_in      = grown_ff;
      word_fresh_in = word_fresh_ff;
      cur_end_in    = cur_end_ff;
      cur_sym_in    = cur_sym_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      req_ready     = (state_ff == enfa_pkg::ST_IDLE);

      case (state_ff)
         enfa_pkg::ST_IDLE: begin
            // word items start a closure; loads finish in the memories
            if (req_fire && ((req_payload.mode == enfa_pkg::MODE_SYMBOL) ||
                             (req_payload.mode == enfa_pkg::MODE_END))) begin
               set_in        = word_fresh_ff ? start_set : set_ff;
               grown_in      = set_in;
               word_fresh_in = 1'b0;
               cnt_in        = '0;
               cur_end_in    = (req_payload.mode == enfa_pkg::MODE_END);
               cur_sym_in    = req_payload.symbol;
               state_in      = enfa_pkg::ST_CLOSE;
            end
         end
         enfa_pkg::ST_CLOSE: begin
            // one pass: union the empty-move rows of all active states
            grown_in = acc;
            if (issue) begin
               cnt_in = cnt_ff + enfa_pkg::SCAN_W'(1);
            end
            if (scan_done) begin
               cnt_in = '0;
               if (acc == set_ff) begin
                  grown_in = '0;
                  state_in = cur_end_ff ? enfa_pkg::ST_REPORT : enfa_pkg::ST_MOVE;
               end else begin
                  set_in = acc;
               end
            end
         end
         enfa_pkg::ST_MOVE: begin
            // union of the symbol rows of all active states
            grown_in = acc;
            if (issue) begin
               cnt_in = cnt_ff + enfa_pkg::SCAN_W'(1);
            end
            if (scan_done) begin
               cnt_in   = '0;
               set_in   = acc;
               state_in = enfa_pkg::ST_IDLE;
            end
         end
         enfa_pkg::ST_REPORT: begin
            // wait for a free output register, then restart the word
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.accepted       = |(set_ff & accept_mask_ff);
               rsp_data_in.no_live_states = (set_ff == '0);
               set_in                     = '0;
               word_fresh_in              = 1'b1;
               state_in                   = enfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = enfa_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= enfa_pkg::ST_IDLE;
         cnt_ff         <= '0;
         rd_live_ff     <= 1'b0;
         set_ff         <= '0;
         word_fresh_ff  <= 1'b1;
         rsp_valid_ff   <= 1'b0;
         start_state_ff <= '0;
         accept_mask_ff <= '0;
         sym_vld_ff     <= '0;
         emp_vld_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_live_ff    <= rd_live_in;
         set_ff        <= set_in;
         word_fresh_ff <= word_fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we && (csr_index == enfa_pkg::CSR_START_STATE)) begin
            start_state_ff <= csr_wdata[enfa_pkg::STATE_W-1:0];
         end
         if (csr_we && (csr_index == enfa_pkg::CSR_ACCEPT_MASK)) begin
            accept_mask_ff <= csr_wdata[enfa_pkg::NUM_STATES-1:0];
         end
         if (sym_we) begin
            sym_vld_ff[sym_wr_addr] <= 1'b1;
         end
         if (emp_we) begin
            emp_vld_ff[req_payload.from_state] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      rd_vld_ff   <= rd_vld_in;
      grown_ff    <= grown_in;
      cur_end_ff  <= cur_end_in;
      cur_sym_ff  <= cur_sym_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for epsilon_nfa_acceptor: directed and random item
// streams, a predictor of the active-set automaton and an in-order checker.
// Depends on enfa_pkg and the RTL of epsilon_nfa_acceptor.
module tb_top;
   import enfa_pkg::*;

   // Worst item is a symbol with 16 closure passes
   localparam int SETTLE_CYCLES  = 300;
   localparam int HOLD_CYCLES    = 1200;
   localparam int WATCHDOG_LIMIT = 20000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   epsilon_nfa_acceptor DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Predictor state: tables, active set and configuration copy
   logic [15:0]   sym_rows [0:SYM_ROWS-1];
   logic [15:0]   eps_rows [0:NUM_STATES-1];
   state_set_type live_set;
   bit            word_fresh;
   logic [3:0]    cfg_start;
   state_set_type cfg_accept;

   req_type pending_items[$];
   rsp_type expected_verdicts[$];

   int send_idle_pct = 8;
   int recv_idle_pct = 56;
   int holds_requested = 0;
   int holds_served = 0;
   int hold_left = 0;
   int items_accepted = 0;
   int verdicts_checked = 0;
   int error_count = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report_error(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic bit chance(int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Close a state set under empty moves
   function automatic state_set_type eps_closure(state_set_type set_in);
      state_set_type grown;
      for (int pass = 0; pass < NUM_STATES; pass++) begin
         grown = set_in;
         for (int s = 0; s < NUM_STATES; s++)
            if (set_in[s]) grown |= eps_rows[s];
         if (grown == set_in) break;
         set_in = grown;
      end
      return set_in;
   endfunction

   // Apply one accepted item to the automaton, queue the verdict at word end
   function automatic void nfa_apply_item(req_type it);
      state_set_type next_set;
      rsp_type       verdict;
      case (it.mode)
         MODE_LOAD_SYM: begin
            sym_rows[int'(it.from_state) * NUM_SYMBOLS + int'(it.symbol)] = it.target_mask;
         end
         MODE_LOAD_EMPTY: begin
            eps_rows[it.from_state] = it.target_mask;
         end
         default: begin
            if (word_fresh) begin
               live_set   = state_set_type'(1) << cfg_start;
               word_fresh = 1'b0;
            end
            live_set = eps_closure(live_set);
            if (it.mode == MODE_SYMBOL) begin
               next_set = '0;
               for (int s = 0; s < NUM_STATES; s++)
                  if (live_set[s]) next_set |= sym_rows[s * NUM_SYMBOLS + int'(it.symbol)];
               live_set = next_set;
            end else begin
               verdict.accepted       = |(live_set & cfg_accept);
               verdict.no_live_states = (live_set == '0);
               expected_verdicts.push_back(verdict);
               live_set   = '0;
               word_fresh = 1'b1;
            end
         end
      endcase
   endfunction

   // Driver: present queued items, hold each until accepted
   always @(posedge clock) begin : drive_req
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            nfa_apply_item(req_payload);
            items_accepted++;
         end
         if (req_valid && !req_ready) begin
            // stalled: keep item as is
         end else if (pending_items.size() != 0 && !chance(send_idle_pct)) begin
            req_valid   <= 1'b1;
            req_payload <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check verdicts in order, pace rsp_ready
   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_error("result item with no word end pending");
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_payload.accepted !== want.accepted)
                  report_error($sformatf("accepted got %b want %b",
                                         rsp_payload.accepted, want.accepted));
               if (rsp_payload.no_live_states !== want.no_live_states)
                  report_error($sformatf("no_live_states got %b want %b",
                                         rsp_payload.no_live_states, want.no_live_states));
            end
            verdicts_checked++;
         end
         // long hold-off so the block backs up into its input
         if (holds_served != holds_requested) begin
            holds_served = holds_requested;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !chance(recv_idle_pct);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   function automatic req_type make_item(mode_type m, int from, int sym, logic [15:0] mask);
      req_type it;
      it.mode        = m;
      it.from_state  = from[3:0];
      it.symbol      = sym[3:0];
      it.target_mask = mask;
      return it;
   endfunction

   // Mostly a small alphabet so words stay alive
   function automatic int pick_symbol();
      return chance(75) ? $urandom_range(3) : $urandom_range(15);
   endfunction

   function automatic logic [15:0] sym_mask();
      case ($urandom_range(9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         default: return (16'h1 << $urandom_range(15)) | (16'h1 << $urandom_range(15));
      endcase
   endfunction

   // Empty moves kept sparse to build chains instead of flooding the set
   function automatic logic [15:0] eps_mask();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return 16'h0000;
         9:             return 16'($urandom);
         default:       return 16'h1 << $urandom_range(15);
      endcase
   endfunction

   function automatic req_type random_load();
      if (chance(50))
         return make_item(MODE_LOAD_SYM, $urandom_range(15), pick_symbol(), sym_mask());
      return make_item(MODE_LOAD_EMPTY, $urandom_range(15), $urandom_range(15), eps_mask());
   endfunction

   // Words with random content, loads mixed in, some noise and unfinished words
   task automatic random_traffic(int count);
      int pushed;
      int len;
      int pick;
      pushed = 0;
      while (pushed < count) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            pending_items.push_back(make_item(mode_type'($urandom_range(3)),
                                              $urandom_range(15), $urandom_range(15),
                                              16'($urandom)));
            pushed++;
         end else if (pick < 35) begin
            pending_items.push_back(random_load());
            pushed++;
         end else begin
            len = $urandom_range(6);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(9) == 0) begin
                  pending_items.push_back(random_load());
                  pushed++;
               end
               pending_items.push_back(make_item(MODE_SYMBOL, $urandom_range(15),
                                                 pick_symbol(), 16'($urandom)));
               pushed++;
            end
            if ($urandom_range(19) != 0) begin
               pending_items.push_back(make_item(MODE_END, $urandom_range(15),
                                                 $urandom_range(15), 16'($urandom)));
               pushed++;
            end
         end
      end
   endtask

   task automatic write_config(logic [3:0] start, logic [15:0] accept);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_START_STATE;
      csr_wdata <= {12'd0, start};
      @(posedge clock);
      csr_index <= CSR_ACCEPT_MASK;
      csr_wdata <= accept;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_start  = start;
      cfg_accept = accept;
      @(negedge clock);
   endtask

   // Wait until every item is in and every verdict is out, then let it settle
   task automatic drain_and_settle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      for (int i = 0; i < SYM_ROWS; i++) sym_rows[i] = '0;
      for (int i = 0; i < NUM_STATES; i++) eps_rows[i] = '0;
      live_set   = '0;
      word_fresh = 1'b1;
      cfg_start  = '0;
      cfg_accept = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_config(4'd0, 16'h8001);

      // Directed: empty word on clear tables
      pending_items.push_back(make_item(MODE_END, 0, 0, 16'h0000));
      // rows with extreme masks; empty-move row ignores its symbol field
      pending_items.push_back(make_item(MODE_LOAD_SYM, 0, 15, 16'h8000));
      pending_items.push_back(make_item(MODE_LOAD_SYM, 15, 0, 16'hFFFF));
      pending_items.push_back(make_item(MODE_LOAD_EMPTY, 15, 15, 16'h0002));
      pending_items.push_back(make_item(MODE_SYMBOL, 15, 15, 16'hFFFF));
      pending_items.push_back(make_item(MODE_END, 15, 15, 16'hFFFF));
      // word that dies: no live states at the end
      pending_items.push_back(make_item(MODE_SYMBOL, 0, 3, 16'h0000));
      pending_items.push_back(make_item(MODE_END, 0, 0, 16'h0000));
      // empty-move chain 15 -> 1 -> 2, then a move to every state
      pending_items.push_back(make_item(MODE_LOAD_EMPTY, 1, 0, 16'h0004));
      pending_items.push_back(make_item(MODE_SYMBOL, 0, 15, 16'h0000));
      pending_items.push_back(make_item(MODE_SYMBOL, 0, 0, 16'h0000));
      pending_items.push_back(make_item(MODE_END, 0, 0, 16'h0000));
      // empty moves after the last symbol reach the accepting state
      pending_items.push_back(make_item(MODE_LOAD_SYM, 0, 1, 16'h0010));
      pending_items.push_back(make_item(MODE_LOAD_EMPTY, 4, 0, 16'h8000));
      pending_items.push_back(make_item(MODE_SYMBOL, 0, 1, 16'h0000));
      pending_items.push_back(make_item(MODE_END, 0, 0, 16'h0000));
      // load in the middle of a word takes effect at once
      pending_items.push_back(make_item(MODE_SYMBOL, 0, 1, 16'h0000));
      pending_items.push_back(make_item(MODE_LOAD_EMPTY, 4, 0, 16'h0000));
      pending_items.push_back(make_item(MODE_END, 0, 0, 16'h0000));
      drain_and_settle();

      // Highest start state, every state accepting
      write_config(4'd15, 16'hFFFF);
      pending_items.push_back(make_item(MODE_END, 0, 0, 16'h0000));
      pending_items.push_back(make_item(MODE_SYMBOL, 0, 0, 16'h0000));
      pending_items.push_back(make_item(MODE_END, 0, 0, 16'h0000));
      drain_and_settle();

      // Random, slow receiver, with one long hold-off
      send_idle_pct = 8;
      recv_idle_pct = 56;
      write_config(4'($urandom_range(15)), 16'($urandom));
      random_traffic(150);
      holds_requested++;
      for (int k = 0; k < 12; k++) begin
         pending_items.push_back(make_item(MODE_SYMBOL, 0, pick_symbol(), 16'($urandom)));
         pending_items.push_back(make_item(MODE_END, 0, 0, 16'($urandom)));
      end
      drain_and_settle();
      random_traffic(150);
      drain_and_settle();

      // Random, slow sender
      send_idle_pct = 56;
      recv_idle_pct = 8;
      write_config(4'($urandom_range(15)), 16'($urandom));
      random_traffic(330);
      drain_and_settle();

      // Random, full rate; nothing accepting, then a random setting
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_config(4'd0, 16'h0000);
      random_traffic(160);
      drain_and_settle();
      write_config(4'($urandom_range(15)), 16'($urandom));
      random_traffic(170);
      drain_and_settle();

      if (expected_verdicts.size() != 0)
         report_error($sformatf("%0d word verdicts never arrived", expected_verdicts.size()));
      $display("Run: %0d items accepted, %0d word verdicts checked, %0d errors",
               items_accepted, verdicts_checked, error_count);
      $display("Covered table loads, word streams, pacing modes and a held receiver");
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/enfa_pkg.sv
hdl/enfa_ram.sv
hdl/epsilon_nfa_acceptor.sv
tb/sv/tb_top.sv
